[design/aifs_pkg.sv]
// shared types and constants of the ascii integer field scanner
package aifs_pkg;

	// base codes
	localparam logic [1:0] BASE_AUTO = 2'd0;
	localparam logic [1:0] BASE_OCT  = 2'd1;
	localparam logic [1:0] BASE_DEC  = 2'd2;
	localparam logic [1:0] BASE_HEX  = 2'd3;

	// status codes
	localparam logic [1:0] ST_SCAN  = 2'd0;
	localparam logic [1:0] ST_OK    = 2'd1;
	localparam logic [1:0] ST_MATCH = 2'd2;
	localparam logic [1:0] ST_INPUT = 2'd3;

	// register indexes
	localparam logic [1:0] REG_BASE_MODE   = 2'd0;
	localparam logic [1:0] REG_SIGNED_MODE = 2'd1;
	localparam logic [1:0] REG_MAX_WIDTH   = 2'd2;

	// characters
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_8     = 8'h38;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] LETTER_OFS = 8'h57;

	localparam int CHARS_W = 10;

	localparam logic [63:0] SAT_SPOS = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SAT_SNEG = 64'h8000_0000_0000_0000;

	// field scan state
	typedef struct packed {
		logic        scan;
		logic        sign_ok;
		logic        have_sign;
		logic        no_digits;
		logic        no_zeros;
		logic        prefix_ok;
		logic [1:0]  base;
		logic [63:0] mag;
		logic        neg;
		logic        ovf;
		logic        last_x;
	} scan_state_t;

	// per-byte result before saturation
	typedef struct packed {
		logic                consumed;
		logic                done;
		logic [1:0]          status;
		logic [CHARS_W-1:0]  used;
		logic [63:0]         mag;
		logic                neg;
		logic                ovf;
		logic                smode;
	} pre_result_t;

endpackage

[design/aifs_scan.sv]
// per-byte field scan: classifies the byte, updates flags and accumulates the digit
module aifs_scan import aifs_pkg::*; #(
	parameter int MAX_FIELD_CHARS = 512
) (
	input  scan_state_t                              st,
	input  logic [$clog2(MAX_FIELD_CHARS+1)-1:0]     cnt,
	input  logic [7:0]                               ch,
	input  logic                                     eoi,
	input  logic [1:0]                               base_mode,
	input  logic                                     signed_mode,
	input  logic [9:0]                               max_width,
	output scan_state_t                              st_n,
	output logic [$clog2(MAX_FIELD_CHARS+1)-1:0]     cnt_n,
	output pre_result_t                              res
);

	localparam int CW = $clog2(MAX_FIELD_CHARS+1);

	logic          blank;
	logic          is_zero, is_19, is_letter, is_sign, is_x;
	logic [7:0]    dig_wide;
	logic [3:0]    dig;
	logic [1:0]    cur_base;
	logic          cur_pfx;
	logic [1:0]    acc_base;
	logic [67:0]   m68, d68, acc;
	logic [CW-1:0] lim;
	logic          legal, add;

	// byte classes
	assign blank     = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
	assign is_zero   = (ch == CH_0);
	assign is_19     = (ch >= CH_1) && (ch <= CH_9);
	assign is_letter = (ch >= CH_LA && ch <= CH_LF) || (ch >= CH_UA && ch <= CH_UF);
	assign is_sign   = (ch == CH_PLUS) || (ch == CH_MINUS);
	assign is_x      = (ch == CH_LX) || (ch == CH_UX);

	// digit value
	assign dig_wide = is_letter ? ((ch | 8'h20) - LETTER_OFS) : (ch - CH_0);
	assign dig      = dig_wide[3:0];

	// base in force for this byte, latched at the first non-blank byte
	assign cur_base = st.scan ? st.base : base_mode;
	assign cur_pfx  = st.scan ? st.prefix_ok : (base_mode == BASE_HEX);
	assign acc_base = (cur_base == BASE_AUTO) ? (is_zero ? BASE_OCT : BASE_DEC) : cur_base;

	// multiply-by-base accumulate, extra top bits flag overflow
	assign m68 = {4'b0, st.mag};
	assign d68 = {64'b0, dig};
	always_comb begin
		case (acc_base)
			BASE_OCT: acc = (m68 << 3) + d68;
			BASE_HEX: acc = (m68 << 4) + d68;
			default:  acc = (m68 << 3) + (m68 << 1) + d68;
		endcase
	end

	// field width limit
	always_comb begin
		if (max_width == 10'd0 || 32'(max_width) > MAX_FIELD_CHARS) begin
			lim = CW'(MAX_FIELD_CHARS);
		end else begin
			lim = CW'(max_width);
		end
	end

	// next state and result
	always_comb begin
		st_n      = st;
		cnt_n     = cnt;
		legal     = 1'b0;
		add       = 1'b0;
		res       = '0;
		res.smode = signed_mode;
		if (!st.scan && blank) begin
			res.consumed = 1'b1;
			if (eoi) begin
				res.done   = 1'b1;
				res.status = ST_INPUT;
			end
		end else begin
			st_n.scan      = 1'b1;
			st_n.base      = cur_base;
			st_n.prefix_ok = cur_pfx;
			if (is_zero) begin
				if (cur_base == BASE_AUTO) begin
					st_n.base      = BASE_OCT;
					st_n.prefix_ok = 1'b1;
				end
				if (st.no_zeros) begin
					st_n.no_zeros = 1'b0;
				end else begin
					st_n.prefix_ok = 1'b0;
				end
				st_n.sign_ok   = 1'b0;
				st_n.no_digits = 1'b0;
				add            = 1'b1;
				legal          = 1'b1;
			end else if (is_19) begin
				if (cur_base == BASE_AUTO) begin
					st_n.base = BASE_DEC;
				end
				if (!(ch >= CH_8 && st_n.base == BASE_OCT)) begin
					st_n.sign_ok   = 1'b0;
					st_n.prefix_ok = 1'b0;
					st_n.no_digits = 1'b0;
					add            = 1'b1;
					legal          = 1'b1;
				end
			end else if (is_letter) begin
				if (cur_base == BASE_HEX) begin
					st_n.sign_ok   = 1'b0;
					st_n.prefix_ok = 1'b0;
					st_n.no_digits = 1'b0;
					add            = 1'b1;
					legal          = 1'b1;
				end
			end else if (is_sign) begin
				if (st.sign_ok) begin
					st_n.sign_ok   = 1'b0;
					st_n.have_sign = 1'b1;
					st_n.neg       = (ch == CH_MINUS);
					legal          = 1'b1;
				end
			end else if (is_x) begin
				if (cur_pfx && cnt == CW'(1) + CW'(st.have_sign)) begin
					st_n.base      = BASE_HEX;
					st_n.prefix_ok = 1'b0;
					legal          = 1'b1;
				end
			end

			// accumulate, or hold the magnitude and flag overflow
			if (add) begin
				if (acc[67:64] != 4'd0) begin
					st_n.ovf = 1'b1;
				end else begin
					st_n.mag = acc[63:0];
				end
			end

			if (legal) begin
				res.consumed = 1'b1;
				cnt_n        = cnt + CW'(1);
				st_n.last_x  = is_x;
				if (eoi || cnt_n >= lim) begin
					res.done = 1'b1;
				end
			end else begin
				res.done = 1'b1;
			end

			if (res.done) begin
				if (st_n.no_digits) begin
					res.status = ST_MATCH;
				end else begin
					res.status = ST_OK;
					res.used   = CHARS_W'(cnt_n - CW'(st_n.last_x));
					res.mag    = st_n.mag;
					res.neg    = st_n.neg;
					res.ovf    = st_n.ovf;
				end
			end
		end

		// rearm for the next field
		if (res.done) begin
			st_n.scan      = 1'b0;
			st_n.sign_ok   = 1'b1;
			st_n.have_sign = 1'b0;
			st_n.no_digits = 1'b1;
			st_n.no_zeros  = 1'b1;
			st_n.prefix_ok = (base_mode == BASE_HEX);
			st_n.base      = base_mode;
			st_n.mag       = '0;
			st_n.neg       = 1'b0;
			st_n.ovf       = 1'b0;
			st_n.last_x    = 1'b0;
			cnt_n          = '0;
		end
	end

endmodule

[design/aifs_sat.sv]
// result conversion: strtoll or strtoull saturation and negation
module aifs_sat import aifs_pkg::*; (
	input  pre_result_t res,
	output logic [63:0] value
);

	logic [63:0] negated;

	assign negated = 64'd0 - res.mag;

	// saturate by signedness, zero unless a good field ends here
	always_comb begin
		value = '0;
		if (res.done && res.status == ST_OK) begin
			if (res.smode) begin
				if (res.neg) begin
					value = (res.ovf || res.mag > SAT_SNEG) ? SAT_SNEG : negated;
				end else begin
					value = (res.ovf || res.mag > SAT_SPOS) ? SAT_SPOS : res.mag;
				end
			end else if (res.ovf) begin
				value = '1;
			end else begin
				value = res.neg ? negated : res.mag;
			end
		end
	end

endmodule

[design/ascii_integer_field_scanner.sv]
// Scans scanf-style integer fields from a byte stream, one request per clock. A byte
// request is taken every cycle while the result side keeps up; its result passes through
// the input register, then the scan register, then the result register. The rate is set
// by the field state loop: flags and the 64-bit multiply-by-base accumulate are updated
// combinationally from one byte and registered together. A result with consumed low asks
// the source to present the same byte again. Configuration registers at 0x0 (base_mode),
// 0x4 (signed_mode) and 0x8 (max_width) are to be written by the user only while no request
// is in flight; the block itself does not enforce it.
module ascii_integer_field_scanner import aifs_pkg::*; #(
	parameter int MAX_FIELD_CHARS = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// byte requests
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  ch,
	input  logic        end_of_input,
	// results
	output logic        result_valid,
	input  logic        result_stall,
	output logic        consumed,
	output logic        field_done,
	output logic [1:0]  status,
	output logic [63:0] value,
	output logic [9:0]  chars_used
);

	localparam int CW = $clog2(MAX_FIELD_CHARS+1);

	// field state after reset: whitespace skipping in decimal
	localparam scan_state_t FIELD_RESET = '{
		scan:      1'b0,
		sign_ok:   1'b1,
		have_sign: 1'b0,
		no_digits: 1'b1,
		no_zeros:  1'b1,
		prefix_ok: 1'b0,
		base:      BASE_DEC,
		mag:       64'd0,
		neg:       1'b0,
		ovf:       1'b0,
		last_x:    1'b0
	};

	logic [1:0]  base_mode_q;
	logic        signed_mode_q;
	logic [9:0]  max_width_q;

	logic        adv;
	logic        valid_s1, valid_s2, result_valid_q;
	logic [7:0]  ch_s1;
	logic        eoi_s1;
	pre_result_t res_s1, res_s2;
	logic [63:0] value_s2;

	scan_state_t   st_q, st_n;
	logic [CW-1:0] cnt_q, cnt_n;

	logic        consumed_q, field_done_q;
	logic [1:0]  status_q;
	logic [63:0] value_q;
	logic [9:0]  chars_used_q;

	// configuration registers
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_mode_q   <= BASE_DEC;
			signed_mode_q <= 1'b1;
			max_width_q   <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_BASE_MODE:   base_mode_q   <= pwdata[1:0];
				REG_SIGNED_MODE: signed_mode_q <= pwdata[0];
				REG_MAX_WIDTH:   max_width_q   <= pwdata[9:0];
				default:         ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[3:2])
			REG_BASE_MODE:   prdata = {30'b0, base_mode_q};
			REG_SIGNED_MODE: prdata = {31'b0, signed_mode_q};
			REG_MAX_WIDTH:   prdata = {22'b0, max_width_q};
			default:         prdata = '0;
		endcase
	end

	// pipeline moves whenever the result register is free or being taken
	assign adv        = !result_valid_q || !result_stall;
	assign byte_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1       <= byte_valid;
			valid_s2       <= valid_s1;
			result_valid_q <= valid_s2;
		end
	end

	// byte scan
	aifs_scan #(
		.MAX_FIELD_CHARS(MAX_FIELD_CHARS)
	) u_scan (
		.st         (st_q),
		.cnt        (cnt_q),
		.ch         (ch_s1),
		.eoi        (eoi_s1),
		.base_mode  (base_mode_q),
		.signed_mode(signed_mode_q),
		.max_width  (max_width_q),
		.st_n       (st_n),
		.cnt_n      (cnt_n),
		.res        (res_s1)
	);

	// field state, updated once per scanned byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= FIELD_RESET;
			cnt_q <= '0;
		end else if (adv && valid_s1) begin
			st_q  <= st_n;
			cnt_q <= cnt_n;
		end
	end

	// saturation stage
	aifs_sat u_sat (
		.res  (res_s2),
		.value(value_s2)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			ch_s1        <= ch;
			eoi_s1       <= end_of_input;
			res_s2       <= res_s1;
			consumed_q   <= res_s2.consumed;
			field_done_q <= res_s2.done;
			status_q     <= res_s2.status;
			value_q      <= value_s2;
			chars_used_q <= res_s2.used;
		end
	end

	assign result_valid = result_valid_q;
	assign consumed     = consumed_q;
	assign field_done   = field_done_q;
	assign status       = status_q;
	assign value        = value_q;
	assign chars_used   = chars_used_q;

	// an unfinished field reports scanning
	a_scan_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !field_done_q |-> status_q == ST_SCAN)
		else $error("unfinished field with final status");

	// a byte handed back always ends its field
	a_giveback_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !consumed_q |-> field_done_q && status_q != ST_INPUT)
		else $error("byte handed back without field end");

	// a finished field rearms into whitespace skipping
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s1 && res_s1.done |=> !st_q.scan && cnt_q == '0)
		else $error("field state not rearmed");

	// character count stays within the field limit
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) < MAX_FIELD_CHARS)
		else $error("field count past limit");

endmodule
